@@ design/gcd_pkg.sv @@
package gcd_pkg;

  localparam int LAT_W = 28;
  localparam int LON_W = 29;
  localparam int RAD_W = 24;
  localparam int DIST_W = 26;
  localparam int CW = 34;
  localparam int SQRT_STAGES = 16;

  localparam longint DEG_TO_RAD_C = 74961321;
  localparam longint CORDIC_INV_GAIN = 652032874;
  localparam longint Q_ONE = longint'(1) << 30;
  localparam longint RND30 = longint'(1) << 29;
  localparam longint DIST_MAX = 67108863;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd1013453;

  typedef logic signed [CW-1:0] cw_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    cw_t z;
  } cordic_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] q;
  } sqrt_t;

  function automatic cw_t atan_q30(input int i);
    longint a;
    case (i)
      0: a = 843314857;
      1: a = 497837829;
      2: a = 263043837;
      3: a = 133525159;
      4: a = 67021687;
      5: a = 33543516;
      6: a = 16775851;
      7: a = 8388437;
      8: a = 4194283;
      9: a = 2097149;
      10: a = 1048576;
      11: a = 524288;
      12: a = 262144;
      13: a = 131072;
      14: a = 65536;
      15: a = 32768;
      16: a = 16384;
      17: a = 8192;
      18: a = 4096;
      19: a = 2048;
      20: a = 1024;
      21: a = 512;
      22: a = 256;
      23: a = 128;
      24: a = 64;
      25: a = 32;
      26: a = 16;
      27: a = 8;
      28: a = 4;
      29: a = 2;
      30: a = 1;
      default: a = 0;
    endcase
    return CW'(a);
  endfunction

endpackage

@@ design/great_circle_distance_unit.sv @@
// Great-circle distance between two points given as latitude and longitude.
// Input channel: in_valid with four coordinate fields, in degrees with
// ANGLE_FRAC_BITS fraction bits; the block drives in_stall. Output channel:
// out_valid with out_distance, in the units of the written radius; the
// receiver drives out_stall. cfg_wr_en with cfg_wr_data writes the radius.
// The pipeline takes one transfer per cycle when not stalled and gives one
// result for each. Its depth is set by the two unrolled CORDIC chains, one
// iteration per stage, by the angle wrap stages (2 at 20 fraction bits)
// and by the square root units, which resolve two root bits per stage.
// All stages advance together. While out_valid is high and out_stall is
// set, the whole pipeline holds and in_stall is raised; nothing is lost or
// repeated. Reset clears all valid bits and loads the Earth radius in 1/256 miles.
module great_circle_distance_unit import gcd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 20,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [LAT_W-1:0]  in_first_latitude,
  input  logic signed [LON_W-1:0]  in_first_longitude,
  input  logic signed [LAT_W-1:0]  in_second_latitude,
  input  logic signed [LON_W-1:0]  in_second_longitude,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DIST_W-1:0]        out_distance,
  input  logic                     cfg_wr_en,
  input  logic [RAD_W-1:0]         cfg_wr_data
);

  localparam int NLANE = 4;
  localparam int UW = 34;
  localparam longint FULL = longint'(360) << ANGLE_FRAC_BITS;
  localparam longint HALF = FULL / 2;
  localparam longint QUARTER = longint'(90) << ANGLE_FRAC_BITS;
  localparam longint OFFS = ((longint'(1) << 30) + FULL - 1) / FULL * FULL;
  localparam longint UMAX = (longint'(1) << 30) + OFFS - 1;

  function automatic int wrap_top();
    int r;
    r = 0;
    for (int k = 23; k >= 0; k--) begin
      if ((FULL << (k + 1)) > UMAX) r = k;
    end
    return r;
  endfunction

  localparam int KTOP = wrap_top();
  localparam int NSTEP = KTOP + 1;
  localparam int WST = (NSTEP + 1) / 2;
  localparam int N = CORDIC_STAGES;
  localparam int LAT = 1 + WST + 3 + N + 4 + SQRT_STAGES + N + 2;

  function automatic logic [UW-1:0] wrap_step(input logic [UW-1:0] u, input int k);
    logic [UW-1:0] m;
    logic [UW-1:0] o;
    o = u;
    if (k >= 0) begin
      m = UW'(FULL << k);
      if (u >= m) o = u - m;
    end
    return o;
  endfunction

  function automatic cordic_t rot_step(input cordic_t c, input int i);
    cordic_t o;
    cw_t xs;
    cw_t ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (!c.z[CW-1]) begin
      o.x = c.x - ys;
      o.y = c.y + xs;
      o.z = c.z - atan_q30(i);
    end else begin
      o.x = c.x + ys;
      o.y = c.y - xs;
      o.z = c.z + atan_q30(i);
    end
    return o;
  endfunction

  function automatic cordic_t vec_step(input cordic_t c, input int i);
    cordic_t o;
    cw_t xs;
    cw_t ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (!c.y[CW-1]) begin
      o.x = c.x + ys;
      o.y = c.y - xs;
      o.z = c.z + atan_q30(i);
    end else begin
      o.x = c.x - ys;
      o.y = c.y + xs;
      o.z = c.z - atan_q30(i);
    end
    return o;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s, input int k);
    logic [63:0] bitk;
    logic [63:0] trial;
    sqrt_t o;
    bitk = 64'd1 << (62 - 2 * k);
    trial = s.q + bitk;
    o = s;
    if (s.v >= trial) begin
      o.v = s.v - trial;
      o.q = (s.q >> 1) + bitk;
    end else begin
      o.q = s.q >> 1;
    end
    return o;
  endfunction

  logic                 ce;
  logic [LAT-1:0]       vld_r, vld_nxt;
  logic [RAD_W-1:0]     radius_r, radius_nxt;
  logic [UW-1:0]        wu_r [WST+1][NLANE];
  logic [UW-1:0]        wu_nxt [WST+1][NLANE];
  logic signed [31:0]   fd_r [NLANE];
  logic signed [31:0]   fd_nxt [NLANE];
  logic [1:0]           fneg_r, fneg_nxt;
  logic signed [59:0]   pm_r [NLANE];
  logic signed [59:0]   pm_nxt [NLANE];
  logic [1:0]           pneg_r, pneg_nxt;
  cw_t                  za_r [NLANE];
  cw_t                  za_nxt [NLANE];
  logic [1:0]           zneg_r, zneg_nxt;
  cordic_t              rot_r [N][NLANE];
  cordic_t              rot_nxt [N][NLANE];
  logic [1:0]           rneg_r [N];
  logic [1:0]           rneg_nxt [N];
  logic signed [63:0]   mt1_r, mt1_nxt, mcc_r, mcc_nxt, mss_r, mss_nxt;
  cw_t                  t1_r, t1_nxt, cc_r, cc_nxt, ss_r, ss_nxt;
  cw_t                  t1b_r, t1b_nxt;
  logic signed [63:0]   mh_r, mh_nxt;
  logic [30:0]          h_r, h_nxt;
  sqrt_t                sq_r [SQRT_STAGES][2];
  sqrt_t                sq_nxt [SQRT_STAGES][2];
  cordic_t              vec_r [N];
  cordic_t              vec_nxt [N];
  logic [55:0]          pd_r, pd_nxt;
  logic [DIST_W-1:0]    dist_r, dist_nxt;

  assign ce = !(out_valid && out_stall);
  assign in_stall = !ce;
  assign out_valid = vld_r[LAT-1];
  assign out_distance = dist_r;

  always_comb begin
    longint s;
    longint a;
    logic neg;
    int sh;
    logic signed [59:0] rnd;
    logic signed [31:0] s1, s2, c1, c2;
    logic signed [34:0] hsum;
    cordic_t ci;
    sqrt_t si;
    logic [30:0] ang;
    logic [56:0] dr;

    vld_nxt = {vld_r[LAT-2:0], in_valid};
    radius_nxt = cfg_wr_en ? cfg_wr_data : radius_r;

    wu_nxt[0][0] = UW'(longint'(in_second_latitude) - longint'(in_first_latitude) + OFFS);
    wu_nxt[0][1] = UW'(longint'(in_second_longitude) - longint'(in_first_longitude) + OFFS);
    wu_nxt[0][2] = UW'(longint'(in_first_latitude) + OFFS);
    wu_nxt[0][3] = UW'(longint'(in_second_latitude) + OFFS);
    for (int j = 0; j < WST; j++) begin
      for (int l = 0; l < NLANE; l++) begin
        wu_nxt[j+1][l] = wrap_step(wrap_step(wu_r[j][l], KTOP - 2 * j), KTOP - 2 * j - 1);
      end
    end

    fneg_nxt = '0;
    for (int l = 0; l < NLANE; l++) begin
      s = longint'(wu_r[WST][l]);
      if (s >= HALF) s = s - FULL;
      if (l >= 2) begin
        a = (s < 0) ? -s : s;
        neg = (a > QUARTER);
        if (neg) a = 2 * QUARTER - a;
        fneg_nxt[l-2] = neg;
        fd_nxt[l] = 32'(a);
      end else begin
        fd_nxt[l] = 32'(s);
      end
    end

    for (int l = 0; l < NLANE; l++) begin
      pm_nxt[l] = 60'(fd_r[l]) * 60'(DEG_TO_RAD_C);
    end
    pneg_nxt = fneg_r;

    for (int l = 0; l < NLANE; l++) begin
      sh = (l < 2) ? ANGLE_FRAC_BITS + 3 : ANGLE_FRAC_BITS + 2;
      rnd = (pm_r[l] + (60'sd1 <<< (sh - 1))) >>> sh;
      za_nxt[l] = CW'(rnd);
    end
    zneg_nxt = pneg_r;

    for (int l = 0; l < NLANE; l++) begin
      ci.x = CW'(CORDIC_INV_GAIN);
      ci.y = '0;
      ci.z = za_r[l];
      rot_nxt[0][l] = rot_step(ci, 0);
    end
    rneg_nxt[0] = zneg_r;
    for (int i = 1; i < N; i++) begin
      for (int l = 0; l < NLANE; l++) begin
        rot_nxt[i][l] = rot_step(rot_r[i-1][l], i);
      end
      rneg_nxt[i] = rneg_r[i-1];
    end

    s1 = 32'(rot_r[N-1][0].y);
    s2 = 32'(rot_r[N-1][1].y);
    c1 = 32'(rot_r[N-1][2].x);
    c2 = 32'(rot_r[N-1][3].x);
    if (rneg_r[N-1][0]) c1 = -c1;
    if (rneg_r[N-1][1]) c2 = -c2;
    mt1_nxt = 64'(s1) * 64'(s1);
    mcc_nxt = 64'(c1) * 64'(c2);
    mss_nxt = 64'(s2) * 64'(s2);

    t1_nxt = CW'((mt1_r + 64'(RND30)) >>> 30);
    cc_nxt = CW'((mcc_r + 64'(RND30)) >>> 30);
    ss_nxt = CW'((mss_r + 64'(RND30)) >>> 30);

    t1b_nxt = t1_r;
    mh_nxt = 64'(32'(cc_r)) * 64'(32'(ss_r));

    hsum = 35'(t1b_r) + 35'((mh_r + 64'(RND30)) >>> 30);
    if (hsum[34]) begin
      h_nxt = '0;
    end else if (hsum > 35'(Q_ONE)) begin
      h_nxt = 31'(Q_ONE);
    end else begin
      h_nxt = 31'(hsum);
    end

    si.q = '0;
    si.v = {3'b000, h_r, 30'b0};
    sq_nxt[0][0] = sqrt_step(sqrt_step(si, 0), 1);
    si.v = {3'b000, 31'(Q_ONE) - h_r, 30'b0};
    sq_nxt[0][1] = sqrt_step(sqrt_step(si, 0), 1);
    for (int j = 1; j < SQRT_STAGES; j++) begin
      for (int l = 0; l < 2; l++) begin
        sq_nxt[j][l] = sqrt_step(sqrt_step(sq_r[j-1][l], 2 * j), 2 * j + 1);
      end
    end

    ci.x = CW'(sq_r[SQRT_STAGES-1][1].q);
    ci.y = CW'(sq_r[SQRT_STAGES-1][0].q);
    ci.z = '0;
    vec_nxt[0] = vec_step(ci, 0);
    for (int i = 1; i < N; i++) begin
      vec_nxt[i] = vec_step(vec_r[i-1], i);
    end

    ang = vec_r[N-1].z[CW-1] ? 31'd0 : 31'(vec_r[N-1].z);
    pd_nxt = 56'({radius_r, 1'b0}) * 56'(ang);

    dr = 57'(pd_r) + 57'(RND30);
    if (dr[56:30] > 27'(DIST_MAX)) begin
      dist_nxt = DIST_W'(DIST_MAX);
    end else begin
      dist_nxt = dr[55:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      radius_r <= RADIUS_RESET;
    end else begin
      radius_r <= radius_nxt;
      if (ce) vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      wu_r <= wu_nxt;
      fd_r <= fd_nxt;
      fneg_r <= fneg_nxt;
      pm_r <= pm_nxt;
      pneg_r <= pneg_nxt;
      za_r <= za_nxt;
      zneg_r <= zneg_nxt;
      rot_r <= rot_nxt;
      rneg_r <= rneg_nxt;
      mt1_r <= mt1_nxt;
      mcc_r <= mcc_nxt;
      mss_r <= mss_nxt;
      t1_r <= t1_nxt;
      cc_r <= cc_nxt;
      ss_r <= ss_nxt;
      t1b_r <= t1b_nxt;
      mh_r <= mh_nxt;
      h_r <= h_nxt;
      sq_r <= sq_nxt;
      vec_r <= vec_nxt;
      pd_r <= pd_nxt;
      dist_r <= dist_nxt;
    end
  end

endmodule

@@ design/gcd_checker.sv @@
module gcd_checker import gcd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DIST_W-1:0] out_distance
);

  // The pipeline holds as a whole, so the input side stalls exactly when a
  // result waits on a stalled receiver.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance))
    else $error("stalled result changed or dropped");

  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

endmodule

bind great_circle_distance_unit gcd_checker u_gcd_checker (.*);
